// File: hdl/line_rasterizer_core_macros.svh
// ----------------------------------------------------------------------------
// line_rasterizer_core_macros
// assertion macros used by the checker file lr_checker
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// property checked at every edge outside reset
`define LR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("line rasterizer check failed");

// property checked at every edge, reset included
`define LR_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("line rasterizer reset check failed");

`endif

// File: hdl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// widths and operation codes of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lr_pkg;

  localparam int CW = 12;          // coordinate width
  localparam int IN_W = 4 * CW;    // packed endpoints
  localparam int IN_BYTES = (IN_W + 7) / 8;
  localparam int OUT_W = 2 * CW;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

endpackage

// File: hdl/line_rasterizer_core.sv
// latency: a step item accepted at one edge shows its point on m_tdata from the next cycle
// throughput: one item per cycle while the output is not stalled; the state registers and
// the result register are each updated by one add and compare stage, so starts and steps
// may follow back to back; a start item produces no result and a step while idle is dropped
// reset: rst, synchronous, clears the active flag and the result valid; no clearing pass
// ----------------------------------------------------------------------------
// line_rasterizer_core
// bresenham line walker with an exact integer error term, one point per step item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // start_x, start_y, end_x, end_y from bit 0 up
  input  logic [8*lr_pkg::IN_BYTES-1:0]   s_tdata,
  // operation
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // point_x, point_y from bit 0 up
  output logic [8*lr_pkg::OUT_BYTES-1:0]  m_tdata,
  // last_point
  output logic                            m_tlast
);

  localparam int CW = lr_pkg::CW;

  logic                 active;
  logic                 axes_swapped;
  logic [CW-1:0]        major_pos;
  logic [CW-1:0]        minor_pos;
  logic [CW-1:0]        major_end;
  logic                 major_neg;
  logic                 minor_neg;
  logic [CW:0]          twice_minor_delta;
  logic [CW-1:0]        major_delta;
  logic signed [CW+1:0] error_acc;

  logic [CW-1:0]        point_x;
  logic [CW-1:0]        point_y;

  logic                 accept;
  lr_pkg::op_t          op;
  logic [CW-1:0]        sx, sy, ex, ey;
  logic [CW-1:0]        dx, dy;
  logic                 swap;
  logic [CW-1:0]        ms, me, ns, ne;
  logic                 last;
  logic                 emit;
  logic signed [CW+2:0] err_sum;
  logic signed [CW+2:0] err_wrap;
  logic                 minor_step;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = lr_pkg::op_t'(s_tuser);

  assign sx = s_tdata[CW-1:0];
  assign sy = s_tdata[2*CW-1:CW];
  assign ex = s_tdata[3*CW-1:2*CW];
  assign ey = s_tdata[4*CW-1:3*CW];

  // endpoint set-up for a start item
  always_comb begin
    dx   = (ex >= sx) ? ex - sx : sx - ex;
    dy   = (ey >= sy) ? ey - sy : sy - ey;
    swap = dy > dx;
    if (swap) begin
      ms = sy; me = ey; ns = sx; ne = ex;
    end else begin
      ms = sx; me = ex; ns = sy; ne = ey;
    end
  end

  // error term: stored value stays in (-major_delta, major_delta]
  always_comb begin
    last       = major_pos == major_end;
    emit       = accept && (op == lr_pkg::OP_STEP) && active;
    err_sum    = $signed({error_acc[CW+1], error_acc}) + $signed({2'b00, twice_minor_delta});
    minor_step = err_sum > $signed({3'b000, major_delta});
    err_wrap   = err_sum - $signed({2'b00, major_delta, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      axes_swapped      <= 1'b0;
      major_pos         <= '0;
      minor_pos         <= '0;
      major_end         <= '0;
      major_neg         <= 1'b0;
      minor_neg         <= 1'b0;
      twice_minor_delta <= '0;
      major_delta       <= '0;
      error_acc         <= '0;
    end else if (accept && op == lr_pkg::OP_START) begin
      active            <= 1'b1;
      axes_swapped      <= swap;
      major_pos         <= ms;
      major_end         <= me;
      minor_pos         <= ns;
      major_neg         <= ms > me;
      minor_neg         <= ne < ns;
      major_delta       <= (me >= ms) ? me - ms : ms - me;
      twice_minor_delta <= {((ne >= ns) ? ne - ns : ns - ne), 1'b0};
      error_acc         <= '0;
    end else if (emit) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        major_pos <= major_neg ? major_pos - 1'b1 : major_pos + 1'b1;
        if (minor_step) begin
          minor_pos <= minor_neg ? minor_pos - 1'b1 : minor_pos + 1'b1;
          error_acc <= err_wrap[CW+1:0];
        end else begin
          error_acc <= err_sum[CW+1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x <= axes_swapped ? minor_pos : major_pos;
      point_y <= axes_swapped ? major_pos : minor_pos;
      m_tlast <= last;
    end
  end

  assign m_tdata = {{(8*lr_pkg::OUT_BYTES-lr_pkg::OUT_W){1'b0}}, point_y, point_x};

endmodule

// File: hdl/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker
// port-level checks of the line rasterizer, bound to line_rasterizer_core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_rasterizer_core_macros.svh"

module lr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [8*lr_pkg::OUT_BYTES-1:0]  m_tdata,
  input logic                            m_tlast
);

  // a stalled result keeps its point
  `LR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // input side only backs off while a result waits
  `LR_ASSERT(a_ready_free, !s_tready |-> m_tvalid && !m_tready)

  // a start item or an idle cycle never makes a fresh result
  `LR_ASSERT(a_start_silent, (!s_tvalid || s_tuser == lr_pkg::OP_START) && m_tready |=> !m_tvalid)

  // nothing is offered right after reset
  `LR_ASSERT_ANY(a_reset_empty, $past(rst) |-> !m_tvalid)

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
